FILE: rtl/ac_ir_frame_transmitter_core_assert.svh
// Assertion helpers for the IR frame transmitter.
`ifndef AC_IR_FRAME_TRANSMITTER_CORE_ASSERT_SVH
`define AC_IR_FRAME_TRANSMITTER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define AC_IR_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ac_ir assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define AC_IR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ac_ir assertion failed");

`endif

FILE: rtl/ac_ir_pkg.sv
`default_nettype none
package ac_ir_pkg;

    typedef enum logic [1:0] {
        OP_SETTINGS = 2'd0,
        OP_OFF      = 2'd1,
        OP_NEXT     = 2'd2,
        OP_RSVD     = 2'd3
    } t_op;

    localparam logic [1:0] CFG_DEF_TEMP = 2'd0;
    localparam logic [1:0] CFG_DEF_MODE = 2'd1;
    localparam logic [1:0] CFG_DEF_FAN  = 2'd2;

    localparam logic [7:0] CH_A = 8'h41;
    localparam logic [7:0] CH_C = 8'h43;
    localparam logic [7:0] CH_D = 8'h44;
    localparam logic [7:0] CH_F = 8'h46;
    localparam logic [7:0] CH_H = 8'h48;
    localparam logic [7:0] CH_L = 8'h4C;
    localparam logic [7:0] CH_M = 8'h4D;
    localparam logic [7:0] CH_N = 8'h4E;

    localparam logic [7:0] RST_DEF_TEMP = 8'd26;
    localparam logic [7:0] RST_DEF_MODE = CH_C;
    localparam logic [7:0] RST_DEF_FAN  = CH_A;

    localparam logic [7:0] OFF_B = 8'h7B;
    localparam logic [7:0] OFF_C = 8'hE0;

    localparam logic [7:0] SEG_COUNT = 8'd199;
    localparam logic [7:0] PACK_SEGS = 8'd98;

    localparam logic [12:0] LEAD_US = 13'd4400;
    localparam logic [12:0] GAP_US  = 13'd5220;
    localparam logic [12:0] ONE_US  = 13'd1620;
    localparam logic [12:0] BIT_US  = 13'd540;

    typedef struct packed {
        logic       ok;
        logic [7:0] code;
    } t_lookup;

    typedef struct packed {
        logic [7:0] temp;
        logic [7:0] mode;
        logic [7:0] fan;
    } t_defaults;

    typedef struct packed {
        logic [7:0] b;
        logic [7:0] c;
    } t_cmd_bytes;

    typedef struct packed {
        logic        segment_valid;
        logic        carrier_on;
        logic [12:0] duration_us;
        logic        last_segment;
    } t_seg;

    function automatic t_lookup fan_lookup(input logic [7:0] f);
        t_lookup r;
        r.ok = 1'b1;
        unique case (f)
            CH_A:    r.code = 8'hBF;
            CH_L:    r.code = 8'h9F;
            CH_M:    r.code = 8'h5F;
            CH_H:    r.code = 8'h3F;
            CH_F:    r.code = 8'h1F;
            default: begin
                r.ok   = 1'b0;
                r.code = 8'h00;
            end
        endcase
        return r;
    endfunction

    function automatic t_lookup temp_lookup(input logic [7:0] t);
        t_lookup r;
        r.ok = 1'b1;
        unique case (t)
            8'd17:   r.code = 8'h00;
            8'd18:   r.code = 8'h10;
            8'd19:   r.code = 8'h30;
            8'd20:   r.code = 8'h20;
            8'd21:   r.code = 8'h60;
            8'd22:   r.code = 8'h70;
            8'd23:   r.code = 8'h50;
            8'd24:   r.code = 8'h40;
            8'd25:   r.code = 8'hC0;
            8'd26:   r.code = 8'hD0;
            8'd27:   r.code = 8'h90;
            8'd28:   r.code = 8'h80;
            8'd29:   r.code = 8'hA0;
            8'd30:   r.code = 8'hB0;
            CH_N:    r.code = 8'hE0;
            default: begin
                r.ok   = 1'b0;
                r.code = 8'h00;
            end
        endcase
        return r;
    endfunction

    function automatic t_lookup mode_lookup(input logic [7:0] m);
        t_lookup r;
        r.ok = 1'b1;
        unique case (m)
            CH_A:    r.code = 8'h08;
            CH_C:    r.code = 8'h00;
            CH_D:    r.code = 8'h04;
            CH_H:    r.code = 8'h0C;
            CH_F:    r.code = 8'h04;
            default: begin
                r.ok   = 1'b0;
                r.code = 8'h00;
            end
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/ac_ir_if.sv
`default_nettype none
interface ac_ir_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] op;
    logic [7:0] unit_id;
    logic [7:0] temperature;
    logic [7:0] mode_char;
    logic [7:0] fan_char;

    modport source (output valid, output op, output unit_id, output temperature,
                    output mode_char, output fan_char, input ready);
    modport sink (input valid, input op, input unit_id, input temperature,
                  input mode_char, input fan_char, output ready);
endinterface

interface ac_ir_out_if;
    logic        valid;
    logic        ready;
    logic        accepted;
    logic        segment_valid;
    logic        carrier_on;
    logic [12:0] duration_us;
    logic        last_segment;

    modport source (output valid, output accepted, output segment_valid,
                    output carrier_on, output duration_us, output last_segment,
                    input ready);
    modport sink (input valid, input accepted, input segment_valid,
                  input carrier_on, input duration_us, input last_segment,
                  output ready);
endinterface

interface ac_ir_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] index;
    logic [7:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

FILE: rtl/ac_ir_frame_transmitter_core.sv
// Channel   Dir  Modport  Word contents
// i_in      in   sink     op, unit_id, temperature, mode_char, fan_char
// i_cfg     in   sink     index, data (default temperature, mode, fan)
// o_out     out  source   accepted, segment_valid, carrier_on, duration_us, last_segment
//
// One word is taken every cycle while the output is not stalled; its result word is offered
// from the edge after the one that accepts it when the output does not stall.
// The path is an input register, the command encoder or segment lookup, and the
// result register; frame state is updated as a word moves into the result register.
// Reset is synchronous: it empties both registers, clears the frame state and loads
// the defaults 26, 'C' and 'A'. A stalled output holds the result register and the input
// register behind it; an empty input register still takes one word, then input ready drops.
`default_nettype none
module ac_ir_frame_transmitter_core (
    input  logic         i_clk,
    input  logic         i_rst_n,
    ac_ir_in_if.sink     i_in,
    ac_ir_cfg_if.sink    i_cfg,
    ac_ir_out_if.source  o_out
);

    `include "ac_ir_frame_transmitter_core_assert.svh"

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] unit_id;
        logic [7:0] temperature;
        logic [7:0] mode_char;
        logic [7:0] fan_char;
    } t_in_word;

    typedef struct packed {
        logic            accepted;
        ac_ir_pkg::t_seg seg;
    } t_out_word;

    ac_ir_pkg::t_defaults  r_defaults;
    logic                  r_in_valid;
    t_in_word              r_in;
    logic                  r_busy;
    logic [7:0]            r_seg_idx;
    logic [23:0]           r_frame;
    logic                  r_out_valid;
    t_out_word             r_out;

    logic                  n_busy;
    logic [7:0]            n_seg_idx;
    logic [23:0]           n_frame;
    t_out_word             n_out;

    logic                  w_adv;
    ac_ir_pkg::t_cmd_bytes w_cmd;
    ac_ir_pkg::t_seg       w_seg;

    ac_ir_cmd_enc u_cmd_enc (
        .i_temperature (r_in.temperature),
        .i_mode_char   (r_in.mode_char),
        .i_fan_char    (r_in.fan_char),
        .i_defaults    (r_defaults),
        .o_bytes       (w_cmd)
    );

    ac_ir_seg_gen u_seg_gen (
        .i_idx   (r_seg_idx),
        .i_frame (r_frame),
        .o_seg   (w_seg)
    );

    assign w_adv       = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready  = !r_in_valid || w_adv;
    assign i_cfg.ready = 1'b1;

    assign o_out.valid         = r_out_valid;
    assign o_out.accepted      = r_out.accepted;
    assign o_out.segment_valid = r_out.seg.segment_valid;
    assign o_out.carrier_on    = r_out.seg.carrier_on;
    assign o_out.duration_us   = r_out.seg.duration_us;
    assign o_out.last_segment  = r_out.seg.last_segment;

    always_comb begin
        n_busy    = r_busy;
        n_seg_idx = r_seg_idx;
        n_frame   = r_frame;
        n_out     = '0;
        unique case (ac_ir_pkg::t_op'(r_in.op))
            ac_ir_pkg::OP_SETTINGS, ac_ir_pkg::OP_OFF: begin
                // Commands are refused while a frame is still going out.
                if (!r_busy) begin
                    n_busy         = 1'b1;
                    n_seg_idx      = '0;
                    n_out.accepted = 1'b1;
                    if (ac_ir_pkg::t_op'(r_in.op) == ac_ir_pkg::OP_SETTINGS) begin
                        n_frame = {r_in.unit_id, w_cmd.b, w_cmd.c};
                    end else begin
                        n_frame = {r_in.unit_id, ac_ir_pkg::OFF_B, ac_ir_pkg::OFF_C};
                    end
                end
            end
            ac_ir_pkg::OP_NEXT: begin
                if (r_busy) begin
                    if (r_seg_idx >= ac_ir_pkg::SEG_COUNT) begin
                        n_busy = 1'b0;
                    end else begin
                        n_out.seg = w_seg;
                        n_seg_idx = r_seg_idx + 8'd1;
                    end
                end
            end
            ac_ir_pkg::OP_RSVD: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_defaults.temp <= ac_ir_pkg::RST_DEF_TEMP;
            r_defaults.mode <= ac_ir_pkg::RST_DEF_MODE;
            r_defaults.fan  <= ac_ir_pkg::RST_DEF_FAN;
            r_in_valid      <= 1'b0;
            r_out_valid     <= 1'b0;
            r_busy          <= 1'b0;
            r_seg_idx       <= '0;
            r_frame         <= '0;
        end else begin
            if (i_cfg.valid) begin
                unique case (i_cfg.index)
                    ac_ir_pkg::CFG_DEF_TEMP: r_defaults.temp <= i_cfg.data;
                    ac_ir_pkg::CFG_DEF_MODE: r_defaults.mode <= i_cfg.data;
                    ac_ir_pkg::CFG_DEF_FAN:  r_defaults.fan  <= i_cfg.data;
                    default: begin
                    end
                endcase
            end
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            if (w_adv) begin
                r_out_valid <= 1'b1;
                r_busy      <= n_busy;
                r_seg_idx   <= n_seg_idx;
                r_frame     <= n_frame;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in.op          <= i_in.op;
            r_in.unit_id     <= i_in.unit_id;
            r_in.temperature <= i_in.temperature;
            r_in.mode_char   <= i_in.mode_char;
            r_in.fan_char    <= i_in.fan_char;
        end
        if (w_adv) begin
            r_out <= n_out;
        end
    end

    // The segment counter never runs past SEG_COUNT, one past the end pulse.
    `AC_IR_ASSERT_NOW(a_idx_range, i_clk, i_rst_n, 1'b1, r_seg_idx <= ac_ir_pkg::SEG_COUNT)

    // The end pulse is always a valid carrier burst.
    `AC_IR_ASSERT_NOW(a_last_carrier, i_clk, i_rst_n, r_out_valid && r_out.seg.last_segment,
        r_out.seg.segment_valid && r_out.seg.carrier_on && !r_out.accepted)

    // An accepted command leaves the block busy at the start of a frame.
    `AC_IR_ASSERT_NEXT(a_cmd_start, i_clk, i_rst_n, w_adv && n_out.accepted,
        r_busy && r_seg_idx == 8'd0 && r_out.accepted)

    // Every delivered segment advances the counter by exactly one.
    `AC_IR_ASSERT_NEXT(a_idx_step, i_clk, i_rst_n, w_adv && n_out.seg.segment_valid,
        r_seg_idx == $past(r_seg_idx) + 8'd1)

endmodule
`default_nettype wire

FILE: rtl/ac_ir_cmd_enc.sv
`default_nettype none
module ac_ir_cmd_enc (
    input  logic [7:0]            i_temperature,
    input  logic [7:0]            i_mode_char,
    input  logic [7:0]            i_fan_char,
    input  ac_ir_pkg::t_defaults  i_defaults,
    output ac_ir_pkg::t_cmd_bytes o_bytes
);

    logic [7:0]         w_mode;
    logic [7:0]         w_temp;
    logic [7:0]         w_fan;
    ac_ir_pkg::t_lookup w_mode_cmd;
    ac_ir_pkg::t_lookup w_mode_def;
    ac_ir_pkg::t_lookup w_fan_cmd;
    ac_ir_pkg::t_lookup w_fan_def;
    ac_ir_pkg::t_lookup w_fan_rst;
    ac_ir_pkg::t_lookup w_temp_cmd;
    ac_ir_pkg::t_lookup w_temp_def;
    ac_ir_pkg::t_lookup w_temp_rst;
    ac_ir_pkg::t_lookup w_mode_res;
    logic [7:0]         w_b;
    logic [7:0]         w_t;

    always_comb begin
        w_mode_cmd = ac_ir_pkg::mode_lookup(i_mode_char);
        w_mode_def = ac_ir_pkg::mode_lookup(i_defaults.mode);

        // An invalid mode takes the default; an invalid default takes cool.
        if (w_mode_cmd.ok) begin
            w_mode = i_mode_char;
        end else if (w_mode_def.ok) begin
            w_mode = i_defaults.mode;
        end else begin
            w_mode = ac_ir_pkg::RST_DEF_MODE;
        end

        w_fan  = i_fan_char;
        w_temp = i_temperature;
        if (w_mode == ac_ir_pkg::CH_A || w_mode == ac_ir_pkg::CH_D) begin
            w_fan = ac_ir_pkg::CH_F;
        end else if (w_mode == ac_ir_pkg::CH_F) begin
            w_temp = ac_ir_pkg::CH_N;
        end

        w_fan_cmd  = ac_ir_pkg::fan_lookup(w_fan);
        w_fan_def  = ac_ir_pkg::fan_lookup(i_defaults.fan);
        w_fan_rst  = ac_ir_pkg::fan_lookup(ac_ir_pkg::RST_DEF_FAN);
        w_temp_cmd = ac_ir_pkg::temp_lookup(w_temp);
        w_temp_def = ac_ir_pkg::temp_lookup(i_defaults.temp);
        w_temp_rst = ac_ir_pkg::temp_lookup(ac_ir_pkg::RST_DEF_TEMP);
        w_mode_res = ac_ir_pkg::mode_lookup(w_mode);

        if (w_fan_cmd.ok) begin
            w_b = w_fan_cmd.code;
        end else if (w_fan_def.ok) begin
            w_b = w_fan_def.code;
        end else begin
            w_b = w_fan_rst.code;
        end

        if (w_temp_cmd.ok) begin
            w_t = w_temp_cmd.code;
        end else if (w_temp_def.ok) begin
            w_t = w_temp_def.code;
        end else begin
            w_t = w_temp_rst.code;
        end

        o_bytes.b = w_b;
        o_bytes.c = w_t | w_mode_res.code;
    end

endmodule
`default_nettype wire

FILE: rtl/ac_ir_seg_gen.sv
`default_nettype none
module ac_ir_seg_gen (
    input  logic [7:0]      i_idx,
    input  logic [23:0]     i_frame,
    output ac_ir_pkg::t_seg o_seg
);

    logic [6:0] w_p;
    logic [6:0] w_q;
    logic [5:0] w_n;
    logic [7:0] w_byte;
    logic       w_bit;

    always_comb begin
        // Position inside the packet: the second copy starts after the gap pair.
        if (i_idx > ac_ir_pkg::PACK_SEGS) begin
            w_p = 7'(i_idx - ac_ir_pkg::PACK_SEGS - 8'd2);
        end else begin
            w_p = i_idx[6:0];
        end
        w_q = 7'(w_p - 7'd2);
        w_n = w_q[6:1];

        unique case (w_n[5:4])
            2'd0:    w_byte = i_frame[23:16];
            2'd1:    w_byte = i_frame[15:8];
            default: w_byte = i_frame[7:0];
        endcase
        // Odd byte slots carry the complement.
        if (w_n[3]) begin
            w_byte = ~w_byte;
        end
        w_bit = w_byte[3'd7 - w_n[2:0]];

        o_seg = '0;
        if (i_idx < ac_ir_pkg::SEG_COUNT) begin
            o_seg.segment_valid = 1'b1;
            if (i_idx == ac_ir_pkg::SEG_COUNT - 8'd1) begin
                o_seg.carrier_on   = 1'b1;
                o_seg.duration_us  = ac_ir_pkg::BIT_US;
                o_seg.last_segment = 1'b1;
            end else if (i_idx == ac_ir_pkg::PACK_SEGS) begin
                o_seg.carrier_on  = 1'b1;
                o_seg.duration_us = ac_ir_pkg::BIT_US;
            end else if (i_idx == ac_ir_pkg::PACK_SEGS + 8'd1) begin
                o_seg.duration_us = ac_ir_pkg::GAP_US;
            end else if (w_p < 7'd2) begin
                o_seg.carrier_on  = (w_p == 7'd0);
                o_seg.duration_us = ac_ir_pkg::LEAD_US;
            end else if (!w_q[0]) begin
                o_seg.carrier_on  = 1'b1;
                o_seg.duration_us = ac_ir_pkg::BIT_US;
            end else begin
                o_seg.duration_us = w_bit ? ac_ir_pkg::ONE_US : ac_ir_pkg::BIT_US;
            end
        end
    end

endmodule
`default_nettype wire
